// ----- rtl/kstg_pkg.sv -----
// ----------------------------------------------------------------------------
// kstg_pkg
// Shared types, request codes and constant tables of the keyed sine tone
// generator: the 64-entry sine table and four octaves of tone periods.
// ----------------------------------------------------------------------------
package kstg_pkg;

    localparam int SAMPLES_PER_CYCLE_DEF = 64;
    localparam int OCTAVE_COUNT_DEF      = 3;
    localparam int SONG_COUNT_DEF        = 4;

    localparam int KEY_COUNT   = 7;
    localparam int KEY_W       = 3;
    localparam int TONE_DEPTH  = 4 * KEY_COUNT;
    localparam int TONE_IDX_W  = $clog2(TONE_DEPTH);
    localparam int PERIOD_W    = 10;
    localparam int PERIOD_MAX  = (1 << PERIOD_W) - 1;
    localparam int SINE_DEPTH  = 64;
    localparam int SAMPLE_W    = 6;
    localparam int OCT_W       = 2;
    localparam int SONG_OUT_W  = 2;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_KEY   = 2'd1,
        REQ_MODE  = 2'd2,
        REQ_CYCLE = 2'd3
    } t_req;

    typedef struct packed {
        t_sample               dac_sample;
        logic                  sample_strobe;
        logic                  sounding;
        logic                  play_mode;
        logic [OCT_W-1:0]      octave_now;
        logic [SONG_OUT_W-1:0] song_now;
    } t_result;

    localparam t_sample SINE_ROM [SINE_DEPTH] = '{
        6'd32, 6'd35, 6'd38, 6'd41, 6'd44, 6'd47, 6'd49, 6'd52,
        6'd54, 6'd56, 6'd58, 6'd59, 6'd61, 6'd62, 6'd62, 6'd63,
        6'd63, 6'd63, 6'd62, 6'd62, 6'd61, 6'd59, 6'd58, 6'd56,
        6'd54, 6'd52, 6'd49, 6'd47, 6'd44, 6'd41, 6'd38, 6'd35,
        6'd32, 6'd29, 6'd26, 6'd23, 6'd20, 6'd17, 6'd15, 6'd12,
        6'd10, 6'd8,  6'd6,  6'd5,  6'd3,  6'd2,  6'd2,  6'd1,
        6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd5,  6'd6,  6'd8,
        6'd10, 6'd12, 6'd15, 6'd17, 6'd20, 6'd23, 6'd26, 6'd29
    };

    // full-wave periods in timer clocks, C through B, four octaves
    localparam int TONE_ROM [TONE_DEPTH] = '{
        30534 * 2, 27211 * 2, 24242 * 2, 22923 * 2, 20408 * 2, 18182 * 2, 16194 * 2,
        15289 * 2, 13621 * 2, 12135 * 2, 11454 * 2, 10204 * 2, 9091 * 2,  8099 * 2,
        7645 * 2,  6810 * 2,  6067 * 2,  5727 * 2,  5102 * 2,  4545 * 2,  4050 * 2,
        3822 * 2,  3405 * 2,  3034 * 2,  2863 * 2,  2551 * 2,  2273 * 2,  2025 * 2
    };

endpackage

// ----- rtl/keyed_sine_tone_generator_core.sv -----
// ----------------------------------------------------------------------------
// keyed_sine_tone_generator_core
// Seven-key piano tone generator with a table sine output, piano and
// auto-play modes, octave and song selection.
// ----------------------------------------------------------------------------
// The block takes one request per clock (tick, key update, mode button or
// cycle button) and returns exactly one result for each, registered in the
// result register or, while that is held, in the skid register. The whole
// state update is combinational between the request transfer and the result
// register, so a new request is accepted every clock as long as results are
// taken; the two-entry output stage keeps input ready independent of output
// ready, and input ready drops only when both entries are full.
module keyed_sine_tone_generator_core #(
    parameter int SAMPLES_PER_CYCLE = kstg_pkg::SAMPLES_PER_CYCLE_DEF,
    parameter int OCTAVE_COUNT      = kstg_pkg::OCTAVE_COUNT_DEF,
    parameter int SONG_COUNT        = kstg_pkg::SONG_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [kstg_pkg::KEY_COUNT-1:0]  i_keys_pressed,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output kstg_pkg::t_sample               o_dac_sample,
    output logic                            o_sample_strobe,
    output logic                            o_sounding,
    output logic                            o_play_mode,
    output logic [kstg_pkg::OCT_W-1:0]      o_octave_now,
    output logic [kstg_pkg::SONG_OUT_W-1:0] o_song_now
);
    import kstg_pkg::*;

    localparam int PHASE_W = $clog2(SAMPLES_PER_CYCLE);
    localparam int SONG_W  = (SONG_COUNT > 1) ? $clog2(SONG_COUNT) : 1;

    t_sample               w_wave_tbl   [SAMPLES_PER_CYCLE];
    logic [PERIOD_W-1:0]   w_period_tbl [TONE_DEPTH];

    logic [PHASE_W-1:0]    r_phase,  n_phase;
    logic [PERIOD_W-1:0]   r_count,  n_count;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic                  r_tone_on, n_tone_on;
    logic                  r_mode,   n_mode;
    logic [OCT_W-1:0]      r_octave, n_octave;
    logic [SONG_W-1:0]     r_song,   n_song;
    t_sample               r_dac,    n_dac;
    logic                  n_strobe;

    logic [KEY_W-1:0]      w_key;
    logic [TONE_IDX_W-1:0] w_tone_idx;
    logic [PHASE_W-1:0]    w_phase_inc;
    logic [PERIOD_W-1:0]   w_new_period;

    t_result               n_result;
    t_result               r_out;
    t_result               r_skid;
    logic                  r_out_valid;
    logic                  r_skid_valid;
    logic                  w_accept;
    logic                  w_take;

    for (genvar g = 0; g < SAMPLES_PER_CYCLE; g++) begin : g_wave
        localparam int IDX = (g * SINE_DEPTH) / SAMPLES_PER_CYCLE;
        assign w_wave_tbl[g] = SINE_ROM[IDX];
    end

    for (genvar g = 0; g < TONE_DEPTH; g++) begin : g_period
        localparam int P_RAW = TONE_ROM[g] / SAMPLES_PER_CYCLE;
        localparam int P_SAT = (P_RAW > PERIOD_MAX) ? PERIOD_MAX : P_RAW;
        assign w_period_tbl[g] = PERIOD_W'(P_SAT);
    end

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_take     = r_out_valid && i_out_ready;

    always_comb begin
        w_key = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (i_keys_pressed[k]) begin
                w_key = KEY_W'(k);
            end
        end
    end

    assign w_tone_idx   = TONE_IDX_W'(r_octave) * TONE_IDX_W'(KEY_COUNT)
                          + TONE_IDX_W'(w_key);
    assign w_new_period = w_period_tbl[w_tone_idx];
    assign w_phase_inc  = (r_phase == PHASE_W'(SAMPLES_PER_CYCLE - 1))
                          ? '0 : r_phase + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_period  = r_period;
        n_tone_on = r_tone_on;
        n_mode    = r_mode;
        n_octave  = r_octave;
        n_song    = r_song;
        n_dac     = r_dac;
        n_strobe  = 1'b0;
        unique case (t_req'(i_req_type))
            REQ_TICK: begin
                if (r_tone_on) begin
                    if (r_count <= PERIOD_W'(1)) begin
                        n_count  = r_period;
                        n_phase  = w_phase_inc;
                        n_dac    = w_wave_tbl[w_phase_inc];
                        n_strobe = 1'b1;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            REQ_KEY: begin
                if (!r_mode) begin
                    if (i_keys_pressed == '0) begin
                        n_tone_on = 1'b0;
                    end else begin
                        n_period  = w_new_period;
                        n_count   = w_new_period;
                        n_tone_on = 1'b1;
                    end
                end
            end
            REQ_MODE: begin
                n_mode = !r_mode;
                if (!r_mode) begin
                    n_octave = '0;
                    n_song   = '0;
                end else begin
                    n_tone_on = 1'b0;
                end
            end
            REQ_CYCLE: begin
                if (!r_mode) begin
                    n_octave = (r_octave == OCT_W'(OCTAVE_COUNT - 1))
                               ? '0 : r_octave + 1'b1;
                end else begin
                    n_octave = '0;
                    n_song   = (r_song == SONG_W'(SONG_COUNT - 1))
                               ? '0 : r_song + 1'b1;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_result.dac_sample    = n_dac;
        n_result.sample_strobe = n_strobe;
        n_result.sounding      = n_tone_on;
        n_result.play_mode     = n_mode;
        n_result.octave_now    = n_octave;
        n_result.song_now      = SONG_OUT_W'(n_song);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_count   <= '0;
            r_period  <= '0;
            r_tone_on <= 1'b0;
            r_mode    <= 1'b0;
            r_octave  <= '0;
            r_song    <= '0;
            r_dac     <= '0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_period  <= n_period;
            r_tone_on <= n_tone_on;
            r_mode    <= n_mode;
            r_octave  <= n_octave;
            r_song    <= n_song;
            r_dac     <= n_dac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept;
                end
            end else if (!r_out_valid) begin
                r_out_valid <= w_accept;
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= n_result;
            end
        end else if (!r_out_valid) begin
            if (w_accept) begin
                r_out <= n_result;
            end
        end else if (w_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_dac_sample    = r_out.dac_sample;
    assign o_sample_strobe = r_out.sample_strobe;
    assign o_sounding      = r_out.sounding;
    assign o_play_mode     = r_out.play_mode;
    assign o_octave_now    = r_out.octave_now;
    assign o_song_now      = r_out.song_now;

endmodule
